FILE: src/rcpd_pkg.sv
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared types and fixed constants of the RC pulse / PPM decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpd_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_EVENT = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_POLL  = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PPM_MODE    = 2'd0,
    CFG_CHANNEL_MAP = 2'd1,
    CFG_MIN_WIDTH   = 2'd2,
    CFG_MAX_WIDTH   = 2'd3
  } cfg_idx_e;

  // Pulse limits in 0.5 us ticks
  localparam logic [15:0] GapLimit     = 16'd4400;
  localparam logic [15:0] SplitMin     = 16'd1600;

  // Failsafe counter ceiling
  localparam logic [4:0]  LossMax      = 5'd20;

  // Widths in microseconds
  localparam logic [11:0] ThrottleIdle = 12'd900;
  localparam logic [11:0] CenterWidth  = 12'd1500;
  localparam logic [11:0] MinReset     = 12'd900;
  localparam logic [11:0] MaxReset     = 12'd2100;

  // Default channel map (identity) and the throttle pin it selects
  localparam logic [23:0] MapReset         = 24'hFAC688;
  localparam logic [2:0]  ThrottleResetPin = MapReset[8:6];

endpackage : rcpd_pkg

`default_nettype wire

FILE: src/rc_pulse_ppm_decoder.sv
// ----------------------------------------------------------------------------
// rc_pulse_ppm_decoder
// Radio-control receiver decoder: separate servo pulses or summed PPM.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one item: a pin-change
//   event, a channel read or a failsafe poll. Reads and polls give one item
//   on the output channel (out_valid_o/out_ready_i); events and the unused
//   function code give none.
//   Configuration is written over cfg_valid_i/cfg_ready_o with a register
//   index and data; cfg_ready_o is always high. Write only while idle.
//   An accepted item is taken into the input register and processed there;
//   its result is loaded into the output register when that register is
//   free or its current result is being taken.
//   Throughput: one item per cycle while no result stalls; the single
//   processing stage updates the pulse state, so the next item always sees it.
//   Reset clears all state to its defaults (centre widths, throttle idle,
//   default map and clamps) at once; no clearing pass is needed.
//   When the receiver stalls, the result is held in the output register.
//   Events keep flowing through; the next read or poll then waits in the
//   input register and holds in_ready_o low until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_ppm_decoder #(
  parameter int CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  pin_levels_i,
  input  logic [15:0] timestamp_i,
  input  logic [2:0]  channel_index_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] width_value_o,
  output logic [4:0]  failsafe_count_o
);

  import rcpd_pkg::*;

  localparam int SlotW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic        ppm_mode_q;
  logic [23:0] map_q;
  logic [11:0] min_q;
  logic [11:0] max_q;

  // input register
  logic        s1_valid_q;
  logic [1:0]  s1_func_q;
  logic [7:0]  s1_levels_q;
  logic [15:0] s1_ts_q;
  logic [2:0]  s1_ch_q;

  // decoder state
  logic [7:0]  prev_q, prev_d;
  logic [15:0] rise_q [CHANNELS];
  logic [15:0] rise_d [CHANNELS];
  logic [11:0] pw_q   [CHANNELS];
  logic [11:0] pw_d   [CHANNELS];
  logic [SlotW-1:0] slot_q, slot_d;
  logic [15:0] last_q, last_d;
  logic [4:0]  loss_q, loss_d;

  // output register
  logic        out_valid_q;
  logic [11:0] out_width_q;
  logic [4:0]  out_loss_q;

  // stage control
  logic        s1_has_result;
  logic        out_free;
  logic        s1_fire;

  // result of the stage
  logic [11:0] res_width;
  logic [4:0]  res_loss;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign cfg_ready_o   = 1'b1;
  assign s1_has_result = (s1_func_q == FUNC_READ) || (s1_func_q == FUNC_POLL);
  assign out_free      = !out_valid_q || out_ready_i;
  assign s1_fire       = s1_valid_q && (!s1_has_result || out_free);
  assign in_ready_o    = !s1_valid_q || s1_fire;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_mode_q <= 1'b0;
      map_q      <= MapReset;
      min_q      <= MinReset;
      max_q      <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PPM_MODE:    ppm_mode_q <= cfg_data_i[0];
        CFG_CHANNEL_MAP: map_q      <= cfg_data_i;
        CFG_MIN_WIDTH:   min_q      <= cfg_data_i[11:0];
        CFG_MAX_WIDTH:   max_q      <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_func_q   <= func_i;
      s1_levels_q <= pin_levels_i;
      s1_ts_q     <= timestamp_i;
      s1_ch_q     <= channel_index_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Processing: state update and result for the item in the input register
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [7:0]  changed;
    logic [2:0]  thr_pin;
    logic [15:0] gap;
    logic [15:0] pulse;
    logic [2:0]  rd_pin;
    logic [11:0] rd_val;
    logic [SlotW:0] slot_inc;

    prev_d   = prev_q;
    rise_d   = rise_q;
    pw_d     = pw_q;
    slot_d   = slot_q;
    last_d   = last_q;
    loss_d   = loss_q;
    res_width = '0;
    res_loss  = '0;

    changed  = s1_levels_q ^ prev_q;
    thr_pin  = map_q[8:6];
    gap      = s1_ts_q - last_q;
    slot_inc = {1'b0, slot_q} + 1'b1;
    pulse    = '0;

    // mapped pin for a read
    rd_pin = '0;
    for (int k = 0; k < 8; k++) begin
      if (s1_ch_q == 3'(k)) rd_pin = map_q[3*k +: 3];
    end
    rd_val = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (rd_pin == 3'(i)) rd_val = pw_q[i];
    end

    case (s1_func_q)
      FUNC_EVENT: begin
        prev_d = s1_levels_q;
        if (ppm_mode_q) begin
          // summed train on pin 0: each high sample closes a slot, or after a long gap restarts at slot 0
          if (s1_levels_q[0]) begin
            if (gap < GapLimit) begin
              for (int i = 0; i < CHANNELS; i++) begin
                if (slot_q == SlotW'(i)) pw_d[i] = gap[12:1];
              end
              slot_d = (slot_inc >= (SlotW+1)'(CHANNELS)) ? '0 : slot_inc[SlotW-1:0];
            end else begin
              slot_d = '0;
            end
            last_d = s1_ts_q;
          end
        end else begin
          // one pulse per pin: rise stamps, fall measures
          for (int p = 0; p < CHANNELS; p++) begin
            pulse = s1_ts_q - rise_q[p];
            if (changed[p]) begin
              if (s1_levels_q[p]) begin
                rise_d[p] = s1_ts_q;
              end else if (pulse > SplitMin && pulse < GapLimit) begin
                pw_d[p] = pulse[12:1];
              end
            end
          end
          // any edge on the throttle pin shows the link is alive
          if (changed[thr_pin]) loss_d = '0;
        end
      end
      FUNC_READ: begin
        if (rd_val < min_q) begin
          res_width = min_q;
        end else if (rd_val > max_q) begin
          res_width = max_q;
        end else begin
          res_width = rd_val;
        end
      end
      FUNC_POLL: begin
        if (loss_q < LossMax) loss_d = loss_q + 5'd1;
        res_loss = loss_d;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Decoder state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      slot_q <= '0;
      last_q <= '0;
      loss_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_q[i] <= '0;
        pw_q[i]   <= (ThrottleResetPin == 3'(i)) ? ThrottleIdle : CenterWidth;
      end
    end else if (s1_fire) begin
      prev_q <= prev_d;
      slot_q <= slot_d;
      last_q <= last_d;
      loss_q <= loss_d;
      rise_q <= rise_d;
      pw_q   <= pw_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_has_result) begin
      out_width_q <= res_width;
      out_loss_q  <= res_loss;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign width_value_o    = out_width_q;
  assign failsafe_count_o = out_loss_q;

endmodule : rc_pulse_ppm_decoder

`default_nettype wire

FILE: src/rcpd_checker.sv
// ----------------------------------------------------------------------------
// rcpd_checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] width_value_o,
  input logic [4:0]  failsafe_count_o
);

  import rcpd_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(width_value_o)
      && $stable(failsafe_count_o))
    else $error("result changed while stalled");

  // failsafe counter saturates
  a_loss_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> failsafe_count_o <= LossMax)
    else $error("failsafe count above ceiling");

  // an item is either a read or a poll, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (width_value_o == 12'd0) || (failsafe_count_o == 5'd0))
    else $error("read and poll fields both set");

  // nothing is offered straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule : rcpd_checker

bind rc_pulse_ppm_decoder rcpd_checker u_rcpd_checker (.*);

`default_nettype wire
